[rtl/htfp_pkg.sv]
// Shared types and constants for the header/tail frame parser.
`default_nettype none
package htfp_pkg;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned PAYLOAD_LEN = 8;
  localparam int unsigned FILL_W      = 4;
  localparam int unsigned SLOT_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_HEAD_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTE = 2'd1;

  localparam logic [15:0] REGION_MIN = 16'd1;
  localparam logic [15:0] REGION_MAX = 16'd9;

  typedef struct packed {
    logic [7:0]  rx_data;
    logic [31:0] time_ms;
  } item_t;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [3:0]  region_id;
    logic        region_ok;
    logic [31:0] stamp_ms;
  } result_t;

endpackage
`default_nettype wire

[rtl/htfp_in_reg.sv]
// Input register stage: holds one received byte and its timestamp.
`default_nettype none
module htfp_in_reg
  import htfp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  wire item_t up_item,
  output logic       dn_valid,
  input  wire logic  dn_ready,
  output item_t      dn_item
);

  logic  valid_r;
  item_t item_r;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      item_r <= up_item;
    end
  end

endmodule
`default_nettype wire

[rtl/htfp_core.sv]
// Frame state, payload store, configuration registers and result decode.
`default_nettype none
module htfp_core
  import htfp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire logic                 item_valid,
  output logic                      item_ready,
  input  wire item_t                item,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output result_t                   res
);

  logic [7:0]        head_byte_r;
  logic [7:0]        tail_byte_r;
  logic              in_frame_r;
  logic              in_frame_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [7:0]        store_r [PAYLOAD_LEN];
  logic              fire;
  logic              store_en;
  logic              payload_full;
  logic              is_head;
  logic              is_tail;
  logic [15:0]       region_copy0;
  logic [15:0]       region_copy1;
  logic              region_ok;

  assign item_ready   = res_ready;
  assign fire         = item_valid && res_ready;
  assign payload_full = fill_r[FILL_W-1];
  assign is_head      = (item.rx_data == head_byte_r);
  assign is_tail      = (item.rx_data == tail_byte_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_byte_r <= 8'd0;
      tail_byte_r <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEAD_BYTE: head_byte_r <= cfg_data;
        REG_TAIL_BYTE: tail_byte_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    fill_nxt     = fill_r;
    store_en     = 1'b0;
    if (fire) begin
      priority if (!in_frame_r) begin
        if (is_head) begin
          in_frame_nxt = 1'b1;
          fill_nxt     = '0;
        end
      end else if (!payload_full) begin
        store_en = 1'b1;
        fill_nxt = fill_r + FILL_W'(1);
      end else if (is_tail) begin
        in_frame_nxt = 1'b0;
        fill_nxt     = '0;
      end else if (is_head) begin
        fill_nxt = '0;
      end else begin
        in_frame_nxt = 1'b0;
        fill_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      fill_r     <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      fill_r     <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      store_r[fill_r[SLOT_W-1:0]] <= item.rx_data;
    end
  end

  assign region_copy0 = {store_r[4], store_r[5]};
  assign region_copy1 = {store_r[6], store_r[7]};
  assign region_ok    = (region_copy0 == region_copy1) && (region_copy0 >= REGION_MIN) &&
                        (region_copy0 <= REGION_MAX);

  assign res_valid     = fire && in_frame_r && payload_full && is_tail;
  assign res.pos_x     = {store_r[0], store_r[1]};
  assign res.pos_y     = {store_r[2], store_r[3]};
  assign res.region_id = region_ok ? region_copy0[3:0] : 4'd0;
  assign res.region_ok = region_ok;
  assign res.stamp_ms  = item.time_ms;

endmodule
`default_nettype wire

[rtl/htfp_out_reg.sv]
// Result register stage: holds one decoded frame until the receiver takes it.
`default_nettype none
module htfp_out_reg
  import htfp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    up_valid,
  output logic         up_ready,
  input  wire result_t up_res,
  output logic         dn_valid,
  input  wire logic    dn_ready,
  output result_t      dn_res
);

  logic    valid_r;
  result_t res_r;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      res_r <= up_res;
    end
  end

endmodule
`default_nettype wire

[rtl/header_tail_frame_parser.sv]
// Header/tail frame parser top level.
//
// Input channel in_valid/in_ready carries one received byte (in_rx_data)
// and the current millisecond tick (in_time_ms) per transfer. Each frame is
// a header byte, eight payload bytes and a tail byte; on a matching tail one
// result leaves on out_valid/out_ready with big-endian X and Y words, the
// checked region number and the tick of the tail byte.
// The cfg_we/cfg_index/cfg_data port sets the header byte (index 0) and the
// tail byte (index 1); other indexes are ignored. Write only while idle.
// Throughput: one byte per cycle while the receiver does not stall. The tail
// byte passes the input register, and its result is then held in the result
// register for the output. Bytes that complete no frame produce no result.
// Reset clears both configuration registers to zero, returns the parser to
// waiting for a header and empties both register stages.
// When the receiver stalls, the result register holds its frame and the
// input register keeps one byte; in_ready drops once both are full.
`default_nettype none
module header_tail_frame_parser
  import htfp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_rx_data,
  input  wire logic [31:0]          in_time_ms,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [15:0]               out_pos_x,
  output logic [15:0]               out_pos_y,
  output logic [3:0]                out_region_id,
  output logic                      out_region_ok,
  output logic [31:0]               out_stamp_ms
);

  item_t   in_item;
  item_t   core_item;
  logic    core_item_valid;
  logic    core_item_ready;
  logic    core_res_valid;
  logic    core_res_ready;
  result_t core_res;
  result_t out_res;

  assign in_item.rx_data = in_rx_data;
  assign in_item.time_ms = in_time_ms;

  htfp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_item  (in_item),
    .dn_valid (core_item_valid),
    .dn_ready (core_item_ready),
    .dn_item  (core_item)
  );

  htfp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (core_item_valid),
    .item_ready (core_item_ready),
    .item       (core_item),
    .res_valid  (core_res_valid),
    .res_ready  (core_res_ready),
    .res        (core_res)
  );

  htfp_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (core_res_valid),
    .up_ready (core_res_ready),
    .up_res   (core_res),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_res   (out_res)
  );

  assign out_pos_x     = out_res.pos_x;
  assign out_pos_y     = out_res.pos_y;
  assign out_region_id = out_res.region_id;
  assign out_region_ok = out_res.region_ok;
  assign out_stamp_ms  = out_res.stamp_ms;

endmodule
`default_nettype wire

[tb/tb_header_tail_frame_parser.sv]
// Self-checking testbench for header_tail_frame_parser with random traffic and stalls.
module tb_header_tail_frame_parser;
  import htfp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int DRAIN_CYCLES = 6;
  localparam int QUIET_LIMIT  = 5000;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_EVERY5, RX_TRICKLE} rx_mode_e;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_rx_data;
  logic [31:0] in_time_ms;
  logic out_valid;
  logic out_ready;
  logic [15:0] out_pos_x;
  logic [15:0] out_pos_y;
  logic [3:0] out_region_id;
  logic out_region_ok;
  logic [31:0] out_stamp_ms;

  header_tail_frame_parser u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_data   (in_rx_data),
    .in_time_ms   (in_time_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pos_x    (out_pos_x),
    .out_pos_y    (out_pos_y),
    .out_region_id(out_region_id),
    .out_region_ok(out_region_ok),
    .out_stamp_ms (out_stamp_ms)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // parser mirror
  logic [7:0]        head_val;
  logic [7:0]        tail_val;
  logic              sync_in_frame;
  logic [FILL_W-1:0] sync_fill;
  logic [7:0]        sync_payload [PAYLOAD_LEN];

  item_t   rx_bytes[$];
  result_t expected_frames[$];
  int      queued_bytes;
  int      accepted_bytes;
  int      err_cnt;
  int      quiet_cycles;
  int      burst_left;
  int      gap_left;
  int      rx_tick;
  rx_mode_e rx_mode;
  item_t   next_byte;

  function automatic void parse_byte(input logic [7:0] b, input logic [31:0] now);
    logic [15:0] reg_a;
    logic [15:0] reg_b;
    result_t fr;
    if (!sync_in_frame) begin
      if (b == head_val) begin
        sync_in_frame = 1'b1;
        sync_fill = '0;
      end
    end else if (sync_fill < PAYLOAD_LEN) begin
      sync_payload[sync_fill[SLOT_W-1:0]] = b;
      sync_fill = sync_fill + FILL_W'(1);
    end else if (b == tail_val) begin
      reg_a = {sync_payload[4], sync_payload[5]};
      reg_b = {sync_payload[6], sync_payload[7]};
      fr.pos_x = {sync_payload[0], sync_payload[1]};
      fr.pos_y = {sync_payload[2], sync_payload[3]};
      fr.region_ok = (reg_a == reg_b) && (reg_a >= REGION_MIN) && (reg_a <= REGION_MAX);
      fr.region_id = fr.region_ok ? reg_a[3:0] : 4'd0;
      fr.stamp_ms = now;
      expected_frames.push_back(fr);
      sync_in_frame = 1'b0;
      sync_fill = '0;
    end else if (b == head_val) begin
      sync_fill = '0;
    end else begin
      sync_in_frame = 1'b0;
      sync_fill = '0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // byte driver
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      parse_byte(in_rx_data, in_time_ms);
      accepted_bytes++;
    end
    if (rst_n && (!in_valid || in_ready)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (rx_bytes.size() != 0) begin
        next_byte = rx_bytes.pop_front();
        in_valid <= 1'b1;
        in_rx_data <= next_byte.rx_data;
        in_time_ms <= next_byte.time_ms;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    rx_tick++;
    if (rx_tick % 97 == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
    end
    case (rx_mode)
      RX_OPEN:    out_ready <= 1'b1;
      RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
      RX_EVERY5:  out_ready <= (rx_tick % 5 == 0);
      RX_TRICKLE: out_ready <= ($urandom_range(0, 9) == 0);
      default:    out_ready <= 1'b1;
    endcase
  end

  // frame monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected frame: expected none, actual x=0x%0h y=0x%0h stamp=0x%0h",
                 $time, out_pos_x, out_pos_y, out_stamp_ms);
        err_cnt++;
      end else begin
        check_field("pos_x", 32'(expected_frames[0].pos_x), 32'(out_pos_x));
        check_field("pos_y", 32'(expected_frames[0].pos_y), 32'(out_pos_y));
        check_field("region_id", 32'(expected_frames[0].region_id), 32'(out_region_id));
        check_field("region_ok", 32'(expected_frames[0].region_ok), 32'(out_region_ok));
        check_field("stamp_ms", expected_frames[0].stamp_ms, out_stamp_ms);
        void'(expected_frames.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("header_tail_frame_parser regression: fail");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b, input logic [31:0] t);
    item_t it;
    it.rx_data = b;
    it.time_ms = t;
    rx_bytes.push_back(it);
    queued_bytes++;
  endtask

  task automatic queue_frame(input bit with_head, input logic [63:0] pl,
                             input logic [7:0] closer, input logic [31:0] t_close);
    if (with_head) begin
      push_byte(head_val, $urandom());
    end
    for (int k = 0; k < 8; k++) begin
      push_byte(pl[63 - 8 * k -: 8], $urandom());
    end
    push_byte(closer, t_close);
  endtask

  function automatic logic [63:0] rand_payload();
    logic [15:0] ra;
    logic [15:0] rb;
    int mode;
    mode = $urandom_range(0, 5);
    if (mode <= 2) begin
      ra = 16'($urandom_range(0, 10));
      rb = ra;
    end else if (mode == 3) begin
      ra = 16'($urandom_range(1, 9));
      rb = ra ^ (16'd1 << $urandom_range(0, 15));
    end else if (mode == 4) begin
      ra = 16'($urandom());
      rb = ra;
    end else begin
      ra = 16'($urandom());
      rb = 16'($urandom());
    end
    return {16'($urandom()), 16'($urandom()), ra, rb};
  endfunction

  task automatic queue_random(input int n_bytes);
    int sent;
    int kind;
    int noise;
    sent = 0;
    while (sent < n_bytes) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        noise = $urandom_range(1, 3);
        repeat (noise) push_byte(8'($urandom()), $urandom());
        sent += noise;
      end else if (kind == 1) begin
        queue_frame(1'b1, rand_payload(), 8'($urandom()), $urandom());
        sent += 10;
      end else if (kind == 2) begin
        queue_frame(1'b1, rand_payload(), head_val, $urandom());
        queue_frame(1'b0, rand_payload(), tail_val, $urandom());
        sent += 19;
      end else begin
        queue_frame(1'b1, rand_payload(), tail_val, $urandom());
        sent += 10;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HEAD_BYTE: head_val = val;
      REG_TAIL_BYTE: tail_val = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (accepted_bytes != queued_bytes || expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] head, input logic [7:0] tail, input int n_bytes);
    wait_drained();
    write_reg(REG_HEAD_BYTE, head);
    write_reg(REG_TAIL_BYTE, tail);
    queue_random(n_bytes);
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_rx_data <= '0;
    in_time_ms <= '0;
    out_ready <= 1'b0;
    head_val = 8'h00;
    tail_val = 8'h00;
    sync_in_frame = 1'b0;
    sync_fill = '0;
    foreach (sync_payload[k]) sync_payload[k] = 8'h00;
    queued_bytes = 0;
    accepted_bytes = 0;
    err_cnt = 0;
    quiet_cycles = 0;
    burst_left = 0;
    gap_left = 0;
    rx_tick = 0;
    rx_mode = RX_OPEN;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    queue_random(100);

    wait_drained();
    write_reg(REG_HEAD_BYTE, 8'hAA);
    write_reg(REG_TAIL_BYTE, 8'h55);
    write_reg(REG_SPARE_2, 8'h12);
    write_reg(REG_SPARE_3, 8'h34);
    push_byte(8'h00, 32'h0000_0000);
    queue_frame(1'b1, 64'hFFFF_0000_0009_0009, 8'h55, 32'hFFFF_FFFF);
    queue_frame(1'b1, 64'hAA55_55AA_0001_0002, 8'hAA, 32'h1234_5678);
    queue_frame(1'b0, 64'h0000_FFFF_0101_0101, 8'h00, 32'h0000_0000);
    queue_random(130);

    run_phase(8'h00, 8'hFF, 130);
    run_phase(8'hFF, 8'h00, 130);
    run_phase(8'h7E, 8'h7E, 130);
    run_phase(8'($urandom()), 8'($urandom()), 130);

    wait_drained();
    if (err_cnt == 0) begin
      $display("header_tail_frame_parser regression: pass");
    end else begin
      $display("header_tail_frame_parser regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/htfp_pkg.sv
rtl/htfp_in_reg.sv
rtl/htfp_core.sv
rtl/htfp_out_reg.sv
rtl/header_tail_frame_parser.sv
tb/tb_header_tail_frame_parser.sv
